// File: src/gts_pkg.sv
package gts_pkg;

   localparam int TABLE_ENTRIES = 65536;
   localparam int STACK_DEPTH   = 256;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SP_W          = $clog2(STACK_DEPTH);
   localparam int CLR_W         = IDX_W + 1;

   localparam logic [1:0] FUNC_READ    = 2'd0;
   localparam logic [1:0] FUNC_WRITE   = 2'd1;
   localparam logic [1:0] FUNC_RESTORE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR   = 2'd3;

   localparam logic [1:0] WIDTH_BYTE = 2'd0;
   localparam logic [1:0] WIDTH_HALF = 2'd1;

   localparam logic CSR_WIDTH   = 1'b0;
   localparam logic CSR_DEFAULT = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic       load;      // capture request word
      logic       tbl_rd;    // issue table read
      logic       stk_rd;    // issue stack read at scan pointer
      logic       push;      // push saved entry, write table
      logic       wr_only;   // table write without push
      logic       cancel;    // negate level of scanned entry if it matches
      logic       restore;   // put back scanned entry if live, pop
      logic       scan_init; // scan pointer <- 0
      logic       scan_next; // scan pointer ++
      logic       top_init;  // restore pointer <- top - 1
      logic       clr_stack;
      logic       clr_step;  // clear one written-bit entry
      logic       respond;
   } gts_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] func;
      logic       level_low;   // write level <= 1
      logic       stack_empty;
      logic       scan_done;   // scan pointer reached top
      logic       rst_stop;    // scanned level below restore level
      logic       clr_done;
   } gts_sts_type;

endpackage

// File: src/grouped_table_with_save_stack_unit.sv
// Read, level-2+ write, clear stack: accepted in IDLE, answered from DECODE via the result register.
// Write at level 1 or below: a stack read and a cancel step for each stack entry, then the table write.
// Restore: a stack read and a pop per entry, until the stack empties or a level is below the restore level.
// Throughput: one word at a time; busy falls as the result strobe rises.
// Reset: synchronous; then the clear sequence walks every written-bit entry, busy high.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
module grouped_table_with_save_stack_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [15:0]        req_index,
   input  logic signed [31:0] req_write_value,
   input  logic [7:0]         req_group_level,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_status
);
   import gts_pkg::*;

   gts_cmd_type cmd;
   gts_sts_type sts;

   // sequencer: clears, decodes, walks the save stack
   gts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // table memory, save stack, config, result word
   gts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_func         (req_func),
      .req_index        (req_index),
      .req_write_value  (req_write_value),
      .req_group_level  (req_group_level),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status)
   );

endmodule

// File: src/gts_ctrl.sv
module gts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gts_pkg::gts_sts_type sts,
   output gts_pkg::gts_cmd_type cmd
);
   import gts_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_SCANRD = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_RSTRD  = 3'd5;
   localparam logic [2:0] S_RST    = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               cmd.tbl_rd = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.func)
               FUNC_READ: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
               FUNC_WRITE: begin
                  if (sts.level_low) begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCANRD;
                  end else begin
                     cmd.push    = 1'b1;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
               FUNC_RESTORE: begin
                  cmd.top_init = 1'b1;
                  state_in     = S_RSTRD;
               end
               default: begin
                  cmd.clr_stack = 1'b1;
                  cmd.respond   = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_SCANRD: begin
            if (sts.scan_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.stk_rd = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.cancel    = 1'b1;
            cmd.scan_next = 1'b1;
            state_in      = S_SCANRD;
         end
         S_RSTRD: begin
            if (sts.stack_empty) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.stk_rd = 1'b1;
               state_in   = S_RST;
            end
         end
         S_RST: begin
            if (sts.rst_stop) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.restore = 1'b1;
               state_in    = S_RSTRD;
            end
         end
         S_FINISH: begin
            cmd.wr_only = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: src/gts_dp.sv
module gts_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [31:0]          csr_write_data,
   input  logic [1:0]           req_func,
   input  logic [15:0]          req_index,
   input  logic signed [31:0]   req_write_value,
   input  logic [7:0]           req_group_level,
   input  gts_pkg::gts_cmd_type cmd,
   output gts_pkg::gts_sts_type sts,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_read_value,
   output logic                 rsp_status
);
   import gts_pkg::*;

   logic [1:0]  width_ff;
   logic [31:0] dflt_ff;

   logic [1:0]  func_ff;
   logic [15:0] idx_ff;
   logic [31:0] val_ff;
   logic [7:0]  lvl_ff;

   logic [31:0] tbl_mem [TABLE_ENTRIES];
   logic        wr_mem  [TABLE_ENTRIES];
   logic [31:0] tbl_q;
   logic        wr_q;

   logic [15:0] sidx_mem [STACK_DEPTH];
   logic [31:0] sval_mem [STACK_DEPTH];
   logic [8:0]  slvl_mem [STACK_DEPTH];
   logic [15:0] sidx_q;
   logic [31:0] sval_q;
   logic [8:0]  slvl_q;

   logic [SP_W:0]  top_ff;
   logic [SP_W:0]  ptr_ff;
   logic [CLR_W-1:0] clr_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 2'd2;
         dflt_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_write_data[1:0];
         else                        dflt_ff  <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         idx_ff  <= req_index;
         val_ff  <= req_write_value;
         lvl_ff  <= req_group_level;
      end
   end

   // default slice, current element view and saturated write value
   logic [31:0] dslice, elem_view, sat_val;
   always_comb begin
      case (width_ff)
         WIDTH_BYTE: dslice = {24'd0, dflt_ff[{idx_ff[1:0], 3'd0} +: 8]};
         WIDTH_HALF: dslice = {16'd0, dflt_ff[{idx_ff[0], 4'd0} +: 16]};
         default:    dslice = dflt_ff;
      endcase
      if (!wr_q) begin
         elem_view = dslice;
      end else begin
         case (width_ff)
            WIDTH_BYTE: elem_view = {24'd0, tbl_q[7:0]};
            WIDTH_HALF: elem_view = {16'd0, tbl_q[15:0]};
            default:    elem_view = tbl_q;
         endcase
      end
      case (width_ff)
         WIDTH_BYTE: sat_val = val_ff[31] ? 32'd0 : ((val_ff > 32'hFF) ? 32'hFF : val_ff);
         WIDTH_HALF: sat_val = val_ff[31] ? 32'd0 :
                               ((val_ff > 32'hFFFF) ? 32'hFFFF : val_ff);
         default:    sat_val = val_ff;
      endcase
   end

   logic [SP_W-1:0] top_m1;
   assign top_m1 = SP_W'(top_ff - 1'b1);
   logic stack_full;
   assign stack_full = top_ff[SP_W];

   logic tbl_we, tbl_we_rst;
   assign tbl_we     = (cmd.push || cmd.wr_only);
   assign tbl_we_rst = cmd.restore && !slvl_q[8];

   always_ff @(posedge clock) begin
      if (cmd.clr_step) wr_mem[clr_ff[IDX_W-1:0]] <= 1'b0;
      else if (tbl_we) wr_mem[idx_ff] <= 1'b1;
      else if (tbl_we_rst) wr_mem[sidx_q] <= 1'b1;
      if (tbl_we) tbl_mem[idx_ff] <= sat_val;
      else if (tbl_we_rst) tbl_mem[sidx_q] <= sval_q;
      if (cmd.tbl_rd) begin
         tbl_q <= tbl_mem[req_index];
         wr_q  <= wr_mem[req_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_step && !clr_ff[IDX_W]) clr_ff <= clr_ff + 1'b1;
   end

   // save stack
   logic [SP_W-1:0] rd_addr;
   assign rd_addr = cmd.top_init ? top_m1 : (ptr_ff[SP_W-1:0]);
   logic cancel_hit;
   assign cancel_hit = (sidx_q == idx_ff) && !slvl_q[8] && (slvl_q != 9'd0);

   always_ff @(posedge clock) begin
      if (cmd.push && !stack_full) begin
         sidx_mem[top_ff[SP_W-1:0]] <= idx_ff;
         sval_mem[top_ff[SP_W-1:0]] <= elem_view;
         slvl_mem[top_ff[SP_W-1:0]] <= {1'b0, lvl_ff};
      end else if (cmd.cancel && cancel_hit) begin
         slvl_mem[ptr_ff[SP_W-1:0]] <= 9'(-slvl_q);
      end
      if (cmd.stk_rd) begin
         sidx_q <= sidx_mem[ptr_ff[SP_W-1:0]];
         sval_q <= sval_mem[ptr_ff[SP_W-1:0]];
         slvl_q <= slvl_mem[ptr_ff[SP_W-1:0]];
      end
   end

   // ptr: scan pointer for cancel, top-1 for restore
   always_ff @(posedge clock) begin
      if (cmd.scan_init)      ptr_ff <= '0;
      else if (cmd.scan_next) ptr_ff <= ptr_ff + 1'b1;
      else if (cmd.top_init)  ptr_ff <= {1'b0, rd_addr};
      else if (cmd.restore && top_ff > 1) ptr_ff <= ptr_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) top_ff <= '0;
      else if (cmd.clr_stack) top_ff <= '0;
      else if (cmd.push && !stack_full) top_ff <= top_ff + 1'b1;
      else if (cmd.restore) top_ff <= top_ff - 1'b1;
   end

   logic [8:0] mag;
   assign mag = slvl_q[8] ? 9'(-slvl_q) : slvl_q;

   assign sts.func        = func_ff;
   assign sts.level_low   = (lvl_ff <= 8'd1);
   assign sts.stack_empty = (top_ff == '0);
   assign sts.scan_done   = (ptr_ff >= top_ff);
   assign sts.rst_stop    = (mag < {1'b0, lvl_ff});
   assign sts.clr_done    = clr_ff[IDX_W];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.respond;
      if (cmd.respond) begin
         rsp_value_ff  <= (func_ff == FUNC_READ) ? elem_view : 32'd0;
         rsp_status_ff <= cmd.push && stack_full;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// File: src/gts_checker.sv
module gts_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_status
);
   import gts_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != FUNC_WRITE) ##2 rsp_valid |-> !rsp_status)
      else $error("status set on non-write");
endmodule

bind grouped_table_with_save_stack_unit gts_checker u_gts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_func(req_func),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status)
);
